// File: src/gmaze_pkg.sv
// ---------------------------------------------------------------------------
// gmaze_pkg
// Shared types and constants of the grid maze depth-first search solver.
// ---------------------------------------------------------------------------
`default_nettype none

package gmaze_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_SOLVE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_LOADED = 3'd0,
    ST_FOUND  = 3'd1,
    ST_NOPATH = 3'd2,
    ST_CELL   = 3'd3,
    ST_NOMORE = 3'd4
  } stat_t;

  localparam logic [1:0] CODE_WALL  = 2'd0;
  localparam logic [1:0] CODE_OPEN  = 2'd1;
  localparam logic [1:0] CODE_ENTRY = 2'd2;
  localparam logic [1:0] CODE_EXIT  = 2'd3;

  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic [7:0] CH_ENTRY_UC = 8'h49;  // I
  localparam logic [7:0] CH_ENTRY_LC = 8'h69;  // i
  localparam logic [7:0] CH_EXIT_UC  = 8'h53;  // S
  localparam logic [7:0] CH_EXIT_LC  = 8'h73;  // s
  localparam logic [7:0] CH_FINISH   = 8'h46;  // F
  localparam logic [7:0] CH_SPACE    = 8'h20;

  typedef struct packed {
    logic  accept;
    logic  clr_start;
    logic  clr_step;
    logic  clr_codes;
    logic  load_wr;
    logic  push_start;
    logic  dir_reset;
    logic  dir_next;
    logic  probe;
    logic  push_nb;
    logic  pop;
    logic  pop_load;
    logic  rd_stack;
    logic  rd_code;
    logic  cur_dec;
    logic  set_found;
    logic  set_fail;
    logic  emit;
    stat_t stat;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic start_ok;
    logic top_goal;
    logic nb_ok;
    logic nb_enter;
    logic dir_last;
    logic depth_one;
    logic rd_ok;
  } sts_t;

  function automatic logic [1:0] code_of(input logic [7:0] ch);
    logic [1:0] code;
    if (ch == CH_ENTRY_UC || ch == CH_ENTRY_LC) begin
      code = CODE_ENTRY;
    end else if (ch == CH_EXIT_UC || ch == CH_EXIT_LC || ch == CH_FINISH) begin
      code = CODE_EXIT;
    end else if (ch == CH_SPACE) begin
      code = CODE_OPEN;
    end else begin
      code = CODE_WALL;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// File: src/gmaze_ctrl.sv
// ---------------------------------------------------------------------------
// gmaze_ctrl
// Sequencer: clearing passes, load, search steps and path readout.
// ---------------------------------------------------------------------------
`default_nettype none

module gmaze_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [1:0]      req_type,
  input  gmaze_pkg::sts_t      sts,
  output gmaze_pkg::cmd_t      cmd,
  output logic                 busy
);
  import gmaze_pkg::*;

  typedef enum logic [3:0] {
    S_RCLR, S_IDLE, S_LOAD, S_SCLR, S_SINIT, S_CHECK,
    S_PROBE, S_EVAL, S_POPW, S_RD1, S_RD2, S_RD3
  } state_t;

  state_t state, state_next;
  req_t   req;

  assign req  = req_t'(req_type);
  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.stat   = ST_LOADED;
    state_next = state;
    case (state)
      S_RCLR: begin
        cmd.clr_step  = 1'b1;
        cmd.clr_codes = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (req)
            REQ_LOAD: state_next = S_LOAD;
            REQ_SOLVE: begin
              cmd.clr_start = 1'b1;
              state_next    = S_SCLR;
            end
            REQ_READ: begin
              if (sts.rd_ok) begin
                state_next = S_RD1;
              end else begin
                cmd.emit = 1'b1;
                cmd.stat = ST_NOMORE;
              end
            end
            default: begin
              cmd.emit = 1'b1;
              cmd.stat = ST_NOMORE;
            end
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_wr = 1'b1;
        cmd.emit    = 1'b1;
        cmd.stat    = ST_LOADED;
        state_next  = S_IDLE;
      end
      S_SCLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_SINIT;
      end
      S_SINIT: begin
        if (sts.start_ok) begin
          cmd.push_start = 1'b1;
          state_next     = S_CHECK;
        end else begin
          cmd.set_fail = 1'b1;
          cmd.emit     = 1'b1;
          cmd.stat     = ST_NOPATH;
          state_next   = S_IDLE;
        end
      end
      S_CHECK: begin
        if (sts.top_goal) begin
          cmd.set_found = 1'b1;
          cmd.emit      = 1'b1;
          cmd.stat      = ST_FOUND;
          state_next    = S_IDLE;
        end else begin
          cmd.dir_reset = 1'b1;
          state_next    = S_PROBE;
        end
      end
      S_PROBE, S_EVAL: begin
        if (state == S_PROBE && sts.nb_ok) begin
          cmd.probe  = 1'b1;
          state_next = S_EVAL;
        end else if (state == S_EVAL && sts.nb_enter) begin
          cmd.push_nb = 1'b1;
          state_next  = S_CHECK;
        end else if (!sts.dir_last) begin
          cmd.dir_next = 1'b1;
          state_next   = S_PROBE;
        end else if (sts.depth_one) begin
          // dead end at the start: search ran dry
          cmd.set_fail = 1'b1;
          cmd.emit     = 1'b1;
          cmd.stat     = ST_NOPATH;
          state_next   = S_IDLE;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_POPW;
        end
      end
      S_POPW: begin
        cmd.pop_load = 1'b1;
        state_next   = S_CHECK;
      end
      S_RD1: begin
        cmd.rd_stack = 1'b1;
        state_next   = S_RD2;
      end
      S_RD2: begin
        cmd.rd_code = 1'b1;
        state_next  = S_RD3;
      end
      S_RD3: begin
        cmd.emit    = 1'b1;
        cmd.stat    = ST_CELL;
        cmd.cur_dec = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RCLR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: src/gmaze_dpath.sv
// ---------------------------------------------------------------------------
// gmaze_dpath
// Cell, visited and stack memories with the search and readout registers.
// ---------------------------------------------------------------------------
`default_nettype none

module gmaze_dpath #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  gmaze_pkg::cmd_t  cmd,
  output gmaze_pkg::sts_t  sts,
  input  wire logic [5:0]  cell_row,
  input  wire logic [5:0]  cell_col,
  input  wire logic [7:0]  cell_char,
  input  wire logic [5:0]  start_row,
  input  wire logic [5:0]  start_col,
  input  wire logic [5:0]  goal_row,
  input  wire logic [5:0]  goal_col,
  output logic             done,
  output logic [2:0]       status,
  output logic [5:0]       out_row,
  output logic [5:0]       out_col,
  output logic             mark,
  output logic             last,
  output logic [12:0]      path_length
);
  import gmaze_pkg::*;

  localparam int NCELLS = GRID_ROWS * GRID_COLS;
  localparam int AW = $clog2(NCELLS);
  localparam int DW = $clog2(NCELLS + 1);
  localparam int RW = $clog2(GRID_ROWS);
  localparam int CW = $clog2(GRID_COLS);
  localparam int EW = RW + CW;

  logic [1:0]    codes [NCELLS];
  logic          vis   [NCELLS];
  logic [EW-1:0] stk   [NCELLS];

  logic [5:0]    in_r, in_c, st_r, st_c, gl_r, gl_c;
  logic [7:0]    in_ch;
  logic [AW-1:0] clr_addr;
  logic [DW-1:0] depth, cursor;
  logic          path_valid;
  logic [1:0]    dir;
  logic [RW-1:0] top_r, nb_r, stk_r;
  logic [CW-1:0] top_c, nb_c, stk_c;
  logic          nb_ok;
  logic [1:0]    code_q;
  logic          vis_q;
  logic [EW-1:0] stk_q;
  logic          load_in;
  logic [AW-1:0] load_idx, start_idx, nb_idx, path_idx, code_raddr;
  logic [DW-1:0] held;
  logic [12:0]   len_v;

  assign stk_r = stk_q[EW-1:CW];
  assign stk_c = stk_q[CW-1:0];

  assign load_in   = (32'(in_r) < GRID_ROWS) && (32'(in_c) < GRID_COLS);
  assign load_idx  = AW'(32'(in_r) * GRID_COLS + 32'(in_c));
  assign start_idx = AW'(32'(st_r) * GRID_COLS + 32'(st_c));
  assign nb_idx    = AW'(32'(nb_r) * GRID_COLS + 32'(nb_c));
  assign path_idx  = AW'(32'(stk_r) * GRID_COLS + 32'(stk_c));
  assign code_raddr = cmd.rd_code ? path_idx : nb_idx;

  always_comb begin
    nb_r  = top_r;
    nb_c  = top_c;
    nb_ok = 1'b0;
    case (dir)
      DIR_DOWN: begin
        nb_r  = top_r + RW'(1);
        nb_ok = (32'(top_r) != GRID_ROWS - 1);
      end
      DIR_RIGHT: begin
        nb_c  = top_c + CW'(1);
        nb_ok = (32'(top_c) != GRID_COLS - 1);
      end
      DIR_UP: begin
        nb_r  = top_r - RW'(1);
        nb_ok = (top_r != '0);
      end
      default: begin
        nb_c  = top_c - CW'(1);
        nb_ok = (top_c != '0);
      end
    endcase
  end

  assign sts.nb_ok     = nb_ok;
  assign sts.clr_last  = (clr_addr == AW'(NCELLS - 1));
  assign sts.start_ok  = (32'(st_r) < GRID_ROWS) && (32'(st_c) < GRID_COLS);
  assign sts.top_goal  = (32'(top_r) == 32'(gl_r)) && (32'(top_c) == 32'(gl_c));
  assign sts.nb_enter  = (code_q == CODE_OPEN || code_q == CODE_EXIT) && !vis_q;
  assign sts.dir_last  = (dir == DIR_LEFT);
  assign sts.depth_one = (depth == DW'(1));
  assign sts.rd_ok     = path_valid && (cursor != '0) && (cursor < depth);

  assign held = (path_valid && depth != '0) ? depth - DW'(1) : '0;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.clr_step && cmd.clr_codes) begin
      codes[clr_addr] <= CODE_WALL;
    end else if (cmd.load_wr && load_in) begin
      codes[load_idx] <= code_of(in_ch);
    end
    if (cmd.probe || cmd.rd_code) code_q <= codes[code_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      vis[clr_addr] <= 1'b0;
    end else if (cmd.push_start) begin
      vis[start_idx] <= 1'b1;
    end else if (cmd.push_nb) begin
      vis[nb_idx] <= 1'b1;
    end
    if (cmd.probe) vis_q <= vis[nb_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.push_start) begin
      stk[0] <= {RW'(st_r), CW'(st_c)};
    end else if (cmd.push_nb) begin
      stk[depth[AW-1:0]] <= {nb_r, nb_c};
    end
    if (cmd.pop) begin
      stk_q <= stk[AW'(depth - DW'(2))];
    end else if (cmd.rd_stack) begin
      stk_q <= stk[cursor[AW-1:0]];
    end
  end

  // latch request fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r  <= cell_row;
      in_c  <= cell_col;
      in_ch <= cell_char;
      st_r  <= start_row;
      st_c  <= start_col;
      gl_r  <= goal_row;
      gl_c  <= goal_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      depth      <= '0;
      cursor     <= '0;
      path_valid <= 1'b0;
      dir        <= DIR_DOWN;
      top_r      <= '0;
      top_c      <= '0;
    end else begin
      if (cmd.clr_start) begin
        clr_addr   <= '0;
        path_valid <= 1'b0;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.load_wr) begin
        path_valid <= 1'b0;
        cursor     <= '0;
      end
      if (cmd.push_start) begin
        depth <= DW'(1);
        top_r <= RW'(st_r);
        top_c <= CW'(st_c);
      end
      if (cmd.push_nb) begin
        depth <= depth + DW'(1);
        top_r <= nb_r;
        top_c <= nb_c;
      end
      if (cmd.pop) depth <= depth - DW'(1);
      if (cmd.pop_load) begin
        top_r <= stk_r;
        top_c <= stk_c;
      end
      if (cmd.dir_reset) begin
        dir <= DIR_DOWN;
      end else if (cmd.dir_next) begin
        dir <= dir + 2'd1;
      end
      if (cmd.set_found) begin
        path_valid <= 1'b1;
        cursor     <= depth - DW'(1);
      end
      if (cmd.set_fail) begin
        path_valid <= 1'b0;
        depth      <= '0;
        cursor     <= '0;
      end
      if (cmd.cur_dec) cursor <= cursor - DW'(1);
    end
  end

  always_comb begin
    case (cmd.stat)
      ST_FOUND:            len_v = 13'(depth - DW'(1));
      ST_CELL, ST_NOMORE:  len_v = 13'(held);
      default:             len_v = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status      <= cmd.stat;
      path_length <= len_v;
      if (cmd.stat == ST_CELL) begin
        out_row <= 6'(stk_r);
        out_col <= 6'(stk_c);
        mark    <= (code_q != CODE_ENTRY) && (code_q != CODE_EXIT);
        last    <= (cursor == DW'(1));
      end else begin
        out_row <= '0;
        out_col <= '0;
        mark    <= 1'b0;
        last    <= 1'b0;
      end
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    32'(depth) <= NCELLS) else $error("stack depth beyond grid size");

  a_cursor_in_path: assert property (@(posedge clk) disable iff (rst)
    path_valid |-> cursor < depth) else $error("read cursor outside held path");

  a_push_unvisited: assert property (@(posedge clk) disable iff (rst)
    cmd.push_nb |-> !vis_q) else $error("pushed a visited cell");

  a_one_stack_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push_start, cmd.push_nb, cmd.pop, cmd.set_fail}))
    else $error("conflicting stack operations");

endmodule

`default_nettype wire

// File: src/grid_maze_dfs_solver_unit.sv
// ---------------------------------------------------------------------------
// grid_maze_dfs_solver_unit
// Grid maze loader and depth-first search solver with path readout.
// ---------------------------------------------------------------------------
// Usage: drive an item with start high while busy is low; it is taken at
// that edge. req_type selects load cell, solve or read next path cell.
// Every item gives exactly one result: done is high for one cycle with
// status, out_row, out_col, mark, last and path_length. The receiver cannot
// stall; results must be taken in that cycle.
// Steps: a load writes the cell, then gives its result; a read reads the
// stack, then the cell, then gives the result; a read with nothing left
// or an unused selector gives its result from the idle state. A solve
// first clears the visited map, one cell a cycle, then walks the search:
// each direction probed reads the cell and visited memories, then is
// evaluated; each pop reads the stack, then loads the new top. While the cell
// memory is cleared to walls after reset, busy is high and no item is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_maze_dfs_solver_unit #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [5:0]  cell_row,
  input  wire logic [5:0]  cell_col,
  input  wire logic [7:0]  cell_char,
  input  wire logic [5:0]  start_row,
  input  wire logic [5:0]  start_col,
  input  wire logic [5:0]  goal_row,
  input  wire logic [5:0]  goal_col,
  output logic             done,
  output logic [2:0]       status,
  output logic [5:0]       out_row,
  output logic [5:0]       out_col,
  output logic             mark,
  output logic             last,
  output logic [12:0]      path_length
);
  import gmaze_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gmaze_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  gmaze_dpath #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cell_row    (cell_row),
    .cell_col    (cell_col),
    .cell_char   (cell_char),
    .start_row   (start_row),
    .start_col   (start_col),
    .goal_row    (goal_row),
    .goal_col    (goal_col),
    .done        (done),
    .status      (status),
    .out_row     (out_row),
    .out_col     (out_col),
    .mark        (mark),
    .last        (last),
    .path_length (path_length)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for grid_maze_dfs_solver_unit: a directed table of
// items, then random maze windows that are loaded, solved and read back.
// Each result is checked against a typed row or an in-bench DFS predictor.
// ---------------------------------------------------------------------------
module tb_top;
  import gmaze_pkg::*;

  localparam int ROWS         = 64;
  localparam int COLS         = 64;
  localparam int NCELL        = ROWS * COLS;
  localparam int ITEM_TARGET  = 1500;
  localparam int CYCLE_LIMIT  = 30_000_000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    req_t       kind;
    logic [5:0] cr;
    logic [5:0] cc;
    logic [7:0] ch;
    logic [5:0] sr;
    logic [5:0] sc;
    logic [5:0] gr;
    logic [5:0] gc;
  } maze_item_t;

  typedef struct {
    logic [2:0]  st;
    logic [5:0]  r;
    logic [5:0]  c;
    logic        mk;
    logic        ls;
    logic [12:0] len;
  } maze_res_t;

  typedef struct {
    maze_item_t item;
    bit         typed;
    maze_res_t  res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [5:0]  cell_row, cell_col, start_row, start_col, goal_row, goal_col;
  logic [7:0]  cell_char;
  logic        done;
  logic [2:0]  status;
  logic [5:0]  out_row, out_col;
  logic        mark, last;
  logic [12:0] path_length;

  grid_maze_dfs_solver_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .cell_row(cell_row), .cell_col(cell_col),
    .cell_char(cell_char), .start_row(start_row), .start_col(start_col),
    .goal_row(goal_row), .goal_col(goal_col), .done(done), .status(status),
    .out_row(out_row), .out_col(out_col), .mark(mark), .last(last),
    .path_length(path_length)
  );

  // predictor state
  logic [1:0]  maze_codes [NCELL];
  bit          seen_map [NCELL];
  logic [11:0] trail [NCELL];
  int          trail_depth;
  int          read_pos;
  bit          path_held;

  maze_res_t   pending_results [$];
  int          fail_count;
  int          items_sent;
  int          cycle_count;
  bit          no_idle;
  int          last_found_len;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("grid_maze_dfs_solver_unit verification failed");
      $finish;
    end
  end

  function automatic logic [1:0] char_class(logic [7:0] ch);
    if (ch == CH_ENTRY_UC || ch == CH_ENTRY_LC) return CODE_ENTRY;
    if (ch == CH_EXIT_UC || ch == CH_EXIT_LC || ch == CH_FINISH) return CODE_EXIT;
    if (ch == CH_SPACE) return CODE_OPEN;
    return CODE_WALL;
  endfunction

  function automatic bit walk_maze(int sr, int sc, int gr, int gc);
    int  top, r, c, nr, nc, d, idx;
    bit  moved;
    foreach (seen_map[i]) seen_map[i] = 1'b0;
    trail[0] = 12'(sr * COLS + sc);
    seen_map[sr * COLS + sc] = 1'b1;
    trail_depth = 1;
    while (trail_depth > 0) begin
      top = trail[trail_depth - 1];
      r = top / COLS;
      c = top % COLS;
      if (r == gr && c == gc) return 1'b1;
      moved = 1'b0;
      // try down, right, up, left
      for (d = 0; d < 4 && !moved; d++) begin
        nr = r + ((d == DIR_DOWN) ? 1 : (d == DIR_UP) ? -1 : 0);
        nc = c + ((d == DIR_RIGHT) ? 1 : (d == DIR_LEFT) ? -1 : 0);
        if (nr >= 0 && nr < ROWS && nc >= 0 && nc < COLS) begin
          idx = nr * COLS + nc;
          if ((maze_codes[idx] == CODE_OPEN || maze_codes[idx] == CODE_EXIT)
              && !seen_map[idx]) begin
            seen_map[idx] = 1'b1;
            trail[trail_depth] = 12'(idx);
            trail_depth++;
            moved = 1'b1;
          end
        end
      end
      if (!moved) trail_depth--;
    end
    return 1'b0;
  endfunction

  function automatic maze_res_t predict_maze(maze_item_t it);
    maze_res_t   res;
    logic [12:0] held;
    int          idx;
    res = '{st: ST_NOMORE, r: 0, c: 0, mk: 0, ls: 0, len: 0};
    held = (path_held && trail_depth > 0) ? 13'(trail_depth - 1) : 13'd0;
    case (it.kind)
      REQ_LOAD: begin
        maze_codes[it.cr * COLS + it.cc] = char_class(it.ch);
        path_held = 1'b0;
        read_pos = 0;
        res.st = ST_LOADED;
      end
      REQ_SOLVE: begin
        if (walk_maze(it.sr, it.sc, it.gr, it.gc)) begin
          path_held = 1'b1;
          read_pos = trail_depth - 1;
          res.st = ST_FOUND;
          res.len = 13'(trail_depth - 1);
        end else begin
          path_held = 1'b0;
          trail_depth = 0;
          read_pos = 0;
          res.st = ST_NOPATH;
        end
      end
      REQ_READ: begin
        res.len = held;
        if (path_held && read_pos > 0 && read_pos < trail_depth) begin
          idx = trail[read_pos];
          res.st = ST_CELL;
          res.r = 6'(idx / COLS);
          res.c = 6'(idx % COLS);
          res.mk = (maze_codes[idx] != CODE_ENTRY && maze_codes[idx] != CODE_EXIT);
          res.ls = (read_pos == 1);
          read_pos--;
        end
      end
      default: res.len = held;
    endcase
    return res;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    maze_res_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with status %0d arrived with none pending", status);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.st, status);
        check_field("out_row", e.r, out_row);
        check_field("out_col", e.c, out_col);
        check_field("mark", e.mk, mark);
        check_field("last", e.ls, last);
        check_field("path_length", e.len, path_length);
      end
    end
  end

  // drive one item, hold it until taken, then log what it should produce
  task automatic send_item(maze_item_t it, bit typed, maze_res_t typed_res);
    int        gap;
    maze_res_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    req_type  <= it.kind;
    cell_row  <= it.cr;
    cell_col  <= it.cc;
    cell_char <= it.ch;
    start_row <= it.sr;
    start_col <= it.sc;
    goal_row  <= it.gr;
    goal_col  <= it.gc;
    do @(posedge clk); while (busy !== 1'b0);
    pred = predict_maze(it);
    pending_results.push_back(typed ? typed_res : pred);
    if (it.kind == REQ_SOLVE) last_found_len = (pred.st == ST_FOUND) ? pred.len : -1;
    items_sent++;
  endtask

  function automatic maze_item_t rand_item(req_t kind);
    maze_item_t it;
    it.kind = kind;
    it.cr = 6'($urandom); it.cc = 6'($urandom); it.ch = 8'($urandom);
    it.sr = 6'($urandom); it.sc = 6'($urandom);
    it.gr = 6'($urandom); it.gc = 6'($urandom);
    return it;
  endfunction

  function automatic logic [7:0] rand_char();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return CH_SPACE;
    if (p < 72) return 8'h23;
    if (p < 76) return CH_ENTRY_UC;
    if (p < 78) return CH_ENTRY_LC;
    if (p < 82) return CH_EXIT_UC;
    if (p < 84) return CH_EXIT_LC;
    if (p < 88) return CH_FINISH;
    return 8'($urandom);
  endfunction

  function automatic dir_row_t row_of(req_t kind, int a, int b, int ch, int sr, int sc,
                                      int gr, int gc, bit typed, stat_t st, int len);
    dir_row_t row;
    row.item = '{kind: kind, cr: 6'(a), cc: 6'(b), ch: 8'(ch), sr: 6'(sr),
                 sc: 6'(sc), gr: 6'(gr), gc: 6'(gc)};
    row.typed = typed;
    row.res = '{st: st, r: 0, c: 0, mk: 0, ls: 0, len: 13'(len)};
    return row;
  endfunction

  initial begin
    dir_row_t   table_rows [$];
    maze_item_t it;
    int         r0, c0, nload, nread, k;
    bit         fill_walls;

    rst = 1'b1; start = 1'b0; req_type = REQ_LOAD;
    cell_row = 0; cell_col = 0; cell_char = 0;
    start_row = 0; start_col = 0; goal_row = 0; goal_col = 0;
    fail_count = 0; items_sent = 0; cycle_count = 0; no_idle = 1'b0;
    last_found_len = -1;
    foreach (maze_codes[i]) maze_codes[i] = CODE_WALL;
    foreach (trail[i]) trail[i] = '0;
    trail_depth = 0; read_pos = 0; path_held = 1'b0;

    table_rows.push_back(row_of(REQ_READ,  0, 0, 0, 0, 0, 0, 0, 1, ST_NOMORE, 0));
    table_rows.push_back(row_of(REQ_NONE,  0, 0, 0, 0, 0, 0, 0, 1, ST_NOMORE, 0));
    table_rows.push_back(row_of(REQ_LOAD,  0, 0, CH_ENTRY_UC, 0, 0, 0, 0, 1, ST_LOADED, 0));
    table_rows.push_back(row_of(REQ_LOAD,  0, 1, CH_SPACE, 0, 0, 0, 0, 1, ST_LOADED, 0));
    table_rows.push_back(row_of(REQ_LOAD,  0, 2, CH_FINISH, 0, 0, 0, 0, 1, ST_LOADED, 0));
    table_rows.push_back(row_of(REQ_LOAD, 63, 63, CH_EXIT_UC, 0, 0, 0, 0, 1, ST_LOADED, 0));
    table_rows.push_back(row_of(REQ_LOAD, 63, 62, CH_EXIT_LC, 0, 0, 0, 0, 1, ST_LOADED, 0));
    table_rows.push_back(row_of(REQ_LOAD, 62, 63, CH_ENTRY_LC, 0, 0, 0, 0, 1, ST_LOADED, 0));
    table_rows.push_back(row_of(REQ_LOAD,  1, 1, 8'hFF, 0, 0, 0, 0, 1, ST_LOADED, 0));
    table_rows.push_back(row_of(REQ_LOAD,  1, 2, 8'h00, 0, 0, 0, 0, 1, ST_LOADED, 0));
    table_rows.push_back(row_of(REQ_SOLVE, 0, 0, 0, 0, 0, 0, 2, 0, ST_FOUND, 0));
    table_rows.push_back(row_of(REQ_READ,  0, 0, 0, 0, 0, 0, 0, 0, ST_CELL, 0));
    table_rows.push_back(row_of(REQ_READ,  0, 0, 0, 0, 0, 0, 0, 0, ST_CELL, 0));
    table_rows.push_back(row_of(REQ_READ,  0, 0, 0, 0, 0, 0, 0, 0, ST_NOMORE, 0));
    // start equals goal
    table_rows.push_back(row_of(REQ_SOLVE, 0, 0, 0, 0, 0, 0, 0, 1, ST_FOUND, 0));
    table_rows.push_back(row_of(REQ_READ,  0, 0, 0, 0, 0, 0, 0, 1, ST_NOMORE, 0));
    // unreachable goal
    table_rows.push_back(row_of(REQ_SOLVE, 0, 0, 0, 0, 0, 40, 40, 1, ST_NOPATH, 0));
    table_rows.push_back(row_of(REQ_READ,  0, 0, 0, 0, 0, 0, 0, 1, ST_NOMORE, 0));
    table_rows.push_back(row_of(REQ_SOLVE, 0, 0, 0, 63, 63, 63, 62, 0, ST_FOUND, 0));
    table_rows.push_back(row_of(REQ_READ,  0, 0, 0, 0, 0, 0, 0, 0, ST_CELL, 0));
    // a load drops the held path
    table_rows.push_back(row_of(REQ_SOLVE, 0, 0, 0, 0, 0, 0, 2, 0, ST_FOUND, 0));
    table_rows.push_back(row_of(REQ_LOAD,  5, 5, CH_SPACE, 0, 0, 0, 0, 1, ST_LOADED, 0));
    table_rows.push_back(row_of(REQ_READ,  0, 0, 0, 0, 0, 0, 0, 1, ST_NOMORE, 0));
    table_rows.push_back(row_of(REQ_NONE, 63, 63, 255, 63, 63, 63, 63, 1, ST_NOMORE, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) send_item(table_rows[i].item, table_rows[i].typed,
                                      table_rows[i].res);

    // let everything drain once before the random part
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    while (items_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r0 = $urandom_range(0, ROWS - 8);
      c0 = $urandom_range(0, COLS - 8);
      fill_walls = ($urandom_range(0, 5) == 0);
      nload = $urandom_range(10, 40);
      for (k = 0; k < nload; k++) begin
        it = rand_item(REQ_LOAD);
        if ($urandom_range(0, 9) != 0) begin
          it.cr = 6'(r0 + $urandom_range(0, 7));
          it.cc = 6'(c0 + $urandom_range(0, 7));
          it.ch = fill_walls ? 8'h23 : rand_char();
        end
        send_item(it, 1'b0, '{default: 0});
      end
      if ($urandom_range(0, 3) == 0) begin
        it = rand_item($urandom_range(0, 1) ? REQ_NONE : REQ_READ);
        send_item(it, 1'b0, '{default: 0});
      end
      it = rand_item(REQ_SOLVE);
      if ($urandom_range(0, 6) != 0) begin
        it.sr = 6'(r0 + $urandom_range(0, 7));
        it.sc = 6'(c0 + $urandom_range(0, 7));
        it.gr = 6'(r0 + $urandom_range(0, 7));
        it.gc = 6'(c0 + $urandom_range(0, 7));
      end
      send_item(it, 1'b0, '{default: 0});
      nread = (last_found_len >= 0) ? last_found_len + $urandom_range(0, 2)
                                    : $urandom_range(0, 2);
      if (nread > 80) nread = 80;
      for (k = 0; k < nread; k++) begin
        it = rand_item(($urandom_range(0, 19) == 0) ? REQ_NONE : REQ_READ);
        send_item(it, 1'b0, '{default: 0});
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("grid_maze_dfs_solver_unit verification clean");
    end else begin
      $display("grid_maze_dfs_solver_unit verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/gmaze_pkg.sv
src/gmaze_ctrl.sv
src/gmaze_dpath.sv
src/grid_maze_dfs_solver_unit.sv
tb/sv/tb_top.sv
